// ===== hw/rtl/dha_pkg.sv =====
// dha_pkg: shared types, constants and helper functions for the dihedral angle block.
// No dependencies; compiled first.
package dha_pkg;

    localparam int IN_W             = 24;   // width of one coordinate field
    localparam int ANGLE_W          = 16;   // width of the angle field
    localparam int RAW_W            = 32;   // zero-extended width of a coordinate field before sign extension
    localparam int COORD_BITS_DEF   = 24;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int MUL_CHUNK  = 17;         // unsigned slice width of the split multiplier
    localparam int SQRT_SHIFT = 32;         // |b2| carries 16 fraction bits
    localparam int X_SHIFT    = 16;         // brings x to the scale of y
    localparam int NORM_BITS  = 30;         // significant bits after normalizing
    localparam int CORDIC_W   = NORM_BITS + 3;
    localparam int Z_W        = 28;         // angle accumulator, 24 fraction bits
    localparam int GRP_LG     = 3;          // leading-one search group, 8 bits
    localparam int PI_Q24     = 52707179;
    localparam int ANGLE_MAX  = 25736;
    localparam int ROUND_BIAS = 1024;
    localparam int OUT_SHIFT  = 11;

    typedef struct packed {
        logic signed [IN_W-1:0] p1_x;
        logic signed [IN_W-1:0] p1_y;
        logic signed [IN_W-1:0] p1_z;
        logic signed [IN_W-1:0] p2_x;
        logic signed [IN_W-1:0] p2_y;
        logic signed [IN_W-1:0] p2_z;
        logic signed [IN_W-1:0] p3_x;
        logic signed [IN_W-1:0] p3_y;
        logic signed [IN_W-1:0] p3_z;
        logic signed [IN_W-1:0] p4_x;
        logic signed [IN_W-1:0] p4_y;
        logic signed [IN_W-1:0] p4_z;
    } in_item_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
    } res_item_t;

    // Latency of dha_mul for operand widths aw and bw: one partial-product
    // stage plus a registered adder tree.
    function automatic int mul_lat(input int aw, input int bw);
        int na;
        int nb;
        na = 0;
        nb = 0;
        for (int w = 0; w < aw; w += MUL_CHUNK) na++;
        for (int w = 0; w < bw; w += MUL_CHUNK) nb++;
        return 1 + $clog2(na * nb);
    endfunction

    // atan(2^-i) with 24 fraction bits, rounded to nearest
    function automatic logic signed [Z_W-1:0] atan_q24(input int i);
        logic signed [Z_W-1:0] r;
        case (i)
            0:       r = Z_W'(13176795);
            1:       r = Z_W'(7778716);
            2:       r = Z_W'(4110060);
            3:       r = Z_W'(2086331);
            4:       r = Z_W'(1047214);
            5:       r = Z_W'(524117);
            6:       r = Z_W'(262123);
            7:       r = Z_W'(131069);
            8:       r = Z_W'(65536);
            9:       r = Z_W'(32768);
            10:      r = Z_W'(16384);
            11:      r = Z_W'(8192);
            12:      r = Z_W'(4096);
            13:      r = Z_W'(2048);
            14:      r = Z_W'(1024);
            15:      r = Z_W'(512);
            16:      r = Z_W'(256);
            17:      r = Z_W'(128);
            18:      r = Z_W'(64);
            19:      r = Z_W'(32);
            20:      r = Z_W'(16);
            21:      r = Z_W'(8);
            22:      r = Z_W'(4);
            23:      r = Z_W'(2);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/dha_stream_if.sv =====
// dha_stream_if: valid/ready channel carrying one payload per transaction.
// Payload type is set by the instantiating level (dha_pkg types).
interface dha_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/dha_mul.sv =====
// dha_mul: pipelined signed multiplier, sliced partial products and a registered
// adder tree, padded to a requested latency. Depends on dha_pkg.
module dha_mul #(
    parameter int AW  = 25,
    parameter int BW  = 25,
    parameter int LAT = 3
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [AW-1:0]  a,
    input  logic signed [BW-1:0]  b,
    output logic signed [AW+BW-1:0] p
);
    import dha_pkg::*;

    localparam int K   = MUL_CHUNK;
    localparam int P   = AW + BW;
    localparam int NA  = (AW + K - 1) / K;
    localparam int NB  = (BW + K - 1) / K;
    localparam int AE  = NA * K;
    localparam int BE  = NB * K;
    localparam int NP  = NA * NB;
    localparam int L   = $clog2(NP);
    localparam int NL  = 1 << L;
    localparam int PX  = P + 2 * K + 2;
    localparam int PAD = LAT - 1 - L;

    logic signed [AE-1:0] a_ext;
    logic signed [BE-1:0] b_ext;
    logic signed [P-1:0]  leaf [NL];
    logic signed [P-1:0]  node_reg [2*NL-1];

    assign a_ext = AE'(a);
    assign b_ext = BE'(b);

    for (genvar i = 0; i < NA; i++) begin : g_a
        for (genvar j = 0; j < NB; j++) begin : g_b
            logic signed [K:0]      sa;
            logic signed [K:0]      sb;
            logic signed [2*K+1:0]  pp;
            logic signed [PX-1:0]   fl;
            if (i == NA - 1) begin : g_sa_top
                assign sa = {a_ext[AE-1], a_ext[i*K +: K]};
            end else begin : g_sa_low
                assign sa = {1'b0, a_ext[i*K +: K]};
            end
            if (j == NB - 1) begin : g_sb_top
                assign sb = {b_ext[BE-1], b_ext[j*K +: K]};
            end else begin : g_sb_low
                assign sb = {1'b0, b_ext[j*K +: K]};
            end
            assign pp = sa * sb;
            assign fl = PX'(pp) <<< ((i + j) * K);
            assign leaf[i*NB + j] = fl[P-1:0];
        end
    end

    for (genvar k = NP; k < NL; k++) begin : g_pad
        assign leaf[k] = '0;
    end

    // heap layout: node k sums children 2k+1 and 2k+2, root at 0
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NL; k++)
                node_reg[NL-1+k] <= leaf[k];
            for (int k = 0; k < NL - 1; k++)
                node_reg[k] <= node_reg[2*k+1] + node_reg[2*k+2];
        end
    end

    if (PAD > 0) begin : g_dly
        logic signed [P-1:0] dly_reg [PAD];
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dly_reg[0] <= node_reg[0];
                for (int d = 1; d < PAD; d++)
                    dly_reg[d] <= dly_reg[d-1];
            end
        end
        assign p = dly_reg[PAD-1];
    end else begin : g_nodly
        assign p = node_reg[0];
    end

endmodule

// ===== hw/rtl/dha_isqrt.sv =====
// dha_isqrt: pipelined floor square root of (rad << SH), one root bit per stage,
// padded to a requested latency. Depends on dha_pkg only through its callers.
module dha_isqrt #(
    parameter int IW  = 52,
    parameter int SH  = 32,
    parameter int LAT = 42
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [IW-1:0]               rad,
    output logic [(IW+SH+1)/2-1:0]      root
);
    localparam int NW   = IW + SH;
    localparam int RW   = (NW + 1) / 2;
    localparam int NW2  = 2 * RW;
    localparam int REMW = RW + 2;
    localparam int PAD  = LAT - RW;

    logic [NW2-1:0]  n_in;
    logic [REMW-1:0] rem_reg  [RW-1];
    logic [NW2-1:0]  n_reg    [RW-1];
    logic [RW-1:0]   root_reg [RW];

    assign n_in = NW2'(rad) << SH;

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [REMW-1:0] rem_in;
        logic [NW2-1:0]  n_cur;
        logic [RW-1:0]   rt_in;
        logic [REMW-1:0] r2;
        logic [REMW-1:0] trial;
        logic            fit;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign n_cur  = n_in;
            assign rt_in  = '0;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign n_cur  = n_reg[k-1];
            assign rt_in  = root_reg[k-1];
        end

        assign r2    = {rem_in[REMW-3:0], n_cur[NW2-1:NW2-2]};
        assign trial = {rt_in, 2'b01};
        assign fit   = (r2 >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
                root_reg[k] <= {rt_in[RW-2:0], fit};
        end

        if (k < RW - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= fit ? (r2 - trial) : r2;
                    n_reg[k]   <= n_cur << 2;
                end
            end
        end
    end

    if (PAD > 0) begin : g_dly
        logic [RW-1:0] dly_reg [PAD];
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dly_reg[0] <= root_reg[RW-1];
                for (int d = 1; d < PAD; d++)
                    dly_reg[d] <= dly_reg[d-1];
            end
        end
        assign root = dly_reg[PAD-1];
    end else begin : g_nodly
        assign root = root_reg[RW-1];
    end

endmodule

// ===== hw/rtl/dihedral_angle_top.sv =====
// dihedral_angle_top: dihedral angle of four points via exact products and CORDIC atan2.
// Stages: bonds, cross products, dot products with |b2|, y = |b2| * t, normalization
//   N1 to N5, CORDIC and the final rounding; the depth G is set by the |b2| square root.
// Throughput: one transaction per cycle; a stalled output freezes the pipeline
//   only once the output register and its skid entry are both full.
// Reset: rst_n clears the valid bits and output handshake state; data is not reset.
module dihedral_angle_top #(
    parameter int COORD_BITS   = dha_pkg::COORD_BITS_DEF,
    parameter int CORDIC_STEPS = dha_pkg::CORDIC_STEPS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    dha_stream_if.sink    pts,
    dha_stream_if.source  res
);
    import dha_pkg::*;

    // ---------------------------------------------------------------
    // Widths. Everything is exact integer math, so each width is the
    // bound of its operation.
    // ---------------------------------------------------------------
    localparam int DW   = COORD_BITS + 1;      // bond vector component
    localparam int PW1  = 2 * DW;              // product of two components
    localparam int XW   = PW1 + 1;             // cross product component
    localparam int SW   = PW1 + 2;             // b2 . b2
    localparam int TPW  = DW + XW;
    localparam int TW   = TPW + 2;             // b1 . (b2 x b3)
    localparam int XPW  = 2 * XW;
    localparam int XSW  = XPW + 2;             // (b1 x b2) . (b2 x b3)
    localparam int RW   = (SW + SQRT_SHIFT + 1) / 2;   // |b2|, 16 fraction bits
    localparam int YW   = RW + 1 + TW;         // y = |b2| * t
    localparam int XAW  = XSW + X_SHIFT;
    localparam int MW   = (YW > XAW) ? YW : XAW;
    localparam int GRP  = 1 << GRP_LG;
    localparam int NG   = (MW + GRP - 1) / GRP;
    localparam int LW   = $clog2(NG * GRP + 1);
    localparam int WW   = MW + NORM_BITS;
    localparam int VW   = Z_W + 1;

    // Pipeline depths
    localparam int LM1  = mul_lat(DW, DW);
    localparam int LT   = mul_lat(DW, XW);
    localparam int LX   = mul_lat(XW, XW);
    localparam int LP2  = (LT > LX) ? LT : LX;
    localparam int G    = (LP2 + 1 > RW) ? LP2 + 1 : RW;
    localparam int LY   = mul_lat(RW + 1, TW);
    localparam int TOT  = LM1 + G + LY + CORDIC_STEPS + 8;

    // ---------------------------------------------------------------
    // Flow control. The whole pipeline advances together; it only
    // stops when the skid entry behind the output register is taken.
    // ---------------------------------------------------------------
    logic           en;
    logic [TOT-1:0] vld_reg;
    logic           out_valid_reg;
    logic           skid_valid_reg;
    logic signed [ANGLE_W-1:0] out_ang_reg;
    logic signed [ANGLE_W-1:0] skid_ang_reg;
    logic           incoming;
    logic           take;

    assign en        = !skid_valid_reg;
    assign pts.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[TOT-2:0], pts.valid};
    end

    // ---------------------------------------------------------------
    // Stage A: coordinates, sign-extended from COORD_BITS, and bonds.
    // ---------------------------------------------------------------
    logic [IN_W-1:0]         fld [4][3];
    logic signed [DW-1:0]    q   [4][3];
    logic signed [DW-1:0]    b1_reg [3];
    logic signed [DW-1:0]    b2_reg [3];
    logic signed [DW-1:0]    b3_reg [3];

    assign fld[0][0] = pts.data.p1_x;
    assign fld[0][1] = pts.data.p1_y;
    assign fld[0][2] = pts.data.p1_z;
    assign fld[1][0] = pts.data.p2_x;
    assign fld[1][1] = pts.data.p2_y;
    assign fld[1][2] = pts.data.p2_z;
    assign fld[2][0] = pts.data.p3_x;
    assign fld[2][1] = pts.data.p3_y;
    assign fld[2][2] = pts.data.p3_z;
    assign fld[3][0] = pts.data.p4_x;
    assign fld[3][1] = pts.data.p4_y;
    assign fld[3][2] = pts.data.p4_z;

    always_comb
    begin
        logic [RAW_W-1:0] raw;
        raw = '0;
        for (int p = 0; p < 4; p++)
            for (int c = 0; c < 3; c++)
            begin
                raw     = RAW_W'(fld[p][c]);
                q[p][c] = DW'($signed(raw[COORD_BITS-1:0]));
            end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            for (int c = 0; c < 3; c++)
            begin
                b1_reg[c] <= q[1][c] - q[0][c];
                b2_reg[c] <= q[2][c] - q[1][c];
                b3_reg[c] <= q[3][c] - q[2][c];
            end
    end

    // ---------------------------------------------------------------
    // Cross products b2 x b3, b1 x b2 and the squares of b2.
    // ---------------------------------------------------------------
    logic signed [PW1-1:0] p23a [3];
    logic signed [PW1-1:0] p23b [3];
    logic signed [PW1-1:0] p12a [3];
    logic signed [PW1-1:0] p12b [3];
    logic signed [PW1-1:0] sq   [3];

    for (genvar k = 0; k < 3; k++) begin : g_cross
        localparam int I1 = (k + 1) % 3;
        localparam int I2 = (k + 2) % 3;
        dha_mul #(.AW(DW), .BW(DW), .LAT(LM1)) u_m23a
            (.clk(clk), .en(en), .a(b2_reg[I1]), .b(b3_reg[I2]), .p(p23a[k]));
        dha_mul #(.AW(DW), .BW(DW), .LAT(LM1)) u_m23b
            (.clk(clk), .en(en), .a(b2_reg[I2]), .b(b3_reg[I1]), .p(p23b[k]));
        dha_mul #(.AW(DW), .BW(DW), .LAT(LM1)) u_m12a
            (.clk(clk), .en(en), .a(b1_reg[I1]), .b(b2_reg[I2]), .p(p12a[k]));
        dha_mul #(.AW(DW), .BW(DW), .LAT(LM1)) u_m12b
            (.clk(clk), .en(en), .a(b1_reg[I2]), .b(b2_reg[I1]), .p(p12b[k]));
        dha_mul #(.AW(DW), .BW(DW), .LAT(LM1)) u_sq
            (.clk(clk), .en(en), .a(b2_reg[k]), .b(b2_reg[k]), .p(sq[k]));
    end

    // b1 rides alongside the cross-product multipliers
    logic signed [DW-1:0] b1d_reg [LM1][3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1d_reg[0] <= b1_reg;
            for (int d = 1; d < LM1; d++)
                b1d_reg[d] <= b1d_reg[d-1];
        end
    end

    // ---------------------------------------------------------------
    // Stage C: cross components and b2 . b2
    // ---------------------------------------------------------------
    logic signed [XW-1:0] c23_reg [3];
    logic signed [XW-1:0] c12_reg [3];
    logic signed [DW-1:0] b1c_reg [3];
    logic signed [SW-1:0] s_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                c23_reg[k] <= XW'(p23a[k]) - XW'(p23b[k]);
                c12_reg[k] <= XW'(p12a[k]) - XW'(p12b[k]);
            end
            b1c_reg <= b1d_reg[LM1-1];
            s_reg   <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
        end
    end

    // ---------------------------------------------------------------
    // Dot products and |b2|, aligned to a common depth G.
    // ---------------------------------------------------------------
    logic signed [TPW-1:0] tp [3];
    logic signed [XPW-1:0] xp [3];
    logic [RW-1:0]         root;

    for (genvar k = 0; k < 3; k++) begin : g_dot
        dha_mul #(.AW(DW), .BW(XW), .LAT(G - 1)) u_mt
            (.clk(clk), .en(en), .a(b1c_reg[k]), .b(c23_reg[k]), .p(tp[k]));
        dha_mul #(.AW(XW), .BW(XW), .LAT(G - 1)) u_mx
            (.clk(clk), .en(en), .a(c12_reg[k]), .b(c23_reg[k]), .p(xp[k]));
    end

    dha_isqrt #(.IW(SW), .SH(SQRT_SHIFT), .LAT(G)) u_sqrt
        (.clk(clk), .en(en), .rad($unsigned(s_reg)), .root(root));

    logic signed [TW-1:0]  t_reg;
    logic signed [XSW-1:0] x_reg;
    logic signed [RW:0]    root_s;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg <= TW'(tp[0]) + TW'(tp[1]) + TW'(tp[2]);
            x_reg <= XSW'(xp[0]) + XSW'(xp[1]) + XSW'(xp[2]);
        end
    end

    assign root_s = {1'b0, root};

    // ---------------------------------------------------------------
    // y = |b2| * t; x waits the same number of cycles.
    // ---------------------------------------------------------------
    logic signed [YW-1:0]  yp;
    logic signed [XSW-1:0] xd_reg [LY];

    dha_mul #(.AW(RW + 1), .BW(TW), .LAT(LY)) u_my
        (.clk(clk), .en(en), .a(root_s), .b(t_reg), .p(yp));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xd_reg[0] <= x_reg;
            for (int d = 1; d < LY; d++)
                xd_reg[d] <= xd_reg[d-1];
        end
    end

    // ---------------------------------------------------------------
    // N1: magnitudes and signs; an exact zero becomes +1 LSB.
    // ---------------------------------------------------------------
    logic signed [MW-1:0] yv;
    logic signed [MW-1:0] xv;
    logic [MW-1:0]        ay1_reg;
    logic [MW-1:0]        ax1_reg;
    logic                 yn1_reg;
    logic                 xn1_reg;

    assign yv = MW'(yp);
    assign xv = MW'(xd_reg[LY-1]) <<< X_SHIFT;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ay1_reg <= (yv == '0) ? MW'(1) : (yv[MW-1] ? MW'(-yv) : MW'(yv));
            ax1_reg <= (xv == '0) ? MW'(1) : (xv[MW-1] ? MW'(-xv) : MW'(xv));
            yn1_reg <= yv[MW-1];
            xn1_reg <= xv[MW-1];
        end
    end

    // ---------------------------------------------------------------
    // N2: leading one inside each 8-bit group of |x| | |y|.
    // ---------------------------------------------------------------
    logic [NG*GRP-1:0]  orv;
    logic [NG-1:0]      gnz;
    logic [GRP_LG-1:0]  gpos [NG];
    logic [NG-1:0]      gnz_reg;
    logic [GRP_LG-1:0]  gpos_reg [NG];
    logic [MW-1:0]      ay2_reg;
    logic [MW-1:0]      ax2_reg;
    logic               yn2_reg;
    logic               xn2_reg;

    assign orv = (NG*GRP)'(ay1_reg | ax1_reg);

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            gnz[g]  = |orv[g*GRP +: GRP];
            gpos[g] = '0;
            for (int b = 0; b < GRP; b++)
                if (orv[g*GRP + b])
                    gpos[g] = GRP_LG'(b);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gnz_reg  <= gnz;
            gpos_reg <= gpos;
            ay2_reg  <= ay1_reg;
            ax2_reg  <= ax1_reg;
            yn2_reg  <= yn1_reg;
            xn2_reg  <= xn1_reg;
        end
    end

    // ---------------------------------------------------------------
    // N3: bit length of the larger magnitude.
    // ---------------------------------------------------------------
    logic [LW-1:0] len;
    logic [LW-1:0] len_reg;
    logic [MW-1:0] ay3_reg;
    logic [MW-1:0] ax3_reg;
    logic          yn3_reg;
    logic          xn3_reg;

    always_comb
    begin
        len = '0;
        for (int g = 0; g < NG; g++)
            if (gnz_reg[g])
                len = LW'(g * GRP) + LW'(gpos_reg[g]) + LW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len_reg <= len;
            ay3_reg <= ay2_reg;
            ax3_reg <= ax2_reg;
            yn3_reg <= yn2_reg;
            xn3_reg <= xn2_reg;
        end
    end

    // ---------------------------------------------------------------
    // N4/N5: take NORM_BITS bits of {mag, NORM_BITS zeros} starting at
    // bit len. Coarse shift by whole groups, then the fine select.
    // ---------------------------------------------------------------
    logic [LW-1:0]     sh;
    logic [WW-1:0]     wcy_reg;
    logic [WW-1:0]     wcx_reg;
    logic [GRP_LG-1:0] lo_reg;
    logic              yn4_reg;
    logic              xn4_reg;

    assign sh = {len_reg[LW-1:GRP_LG], GRP_LG'(0)};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wcy_reg <= {ay3_reg, NORM_BITS'(0)} >> sh;
            wcx_reg <= {ax3_reg, NORM_BITS'(0)} >> sh;
            lo_reg  <= len_reg[GRP_LG-1:0];
            yn4_reg <= yn3_reg;
            xn4_reg <= xn3_reg;
        end
    end

    logic signed [CORDIC_W-1:0] cx0_reg;
    logic signed [CORDIC_W-1:0] cy0_reg;
    logic                       yn5_reg;
    logic                       xn5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx0_reg <= CORDIC_W'(wcx_reg[lo_reg +: NORM_BITS]);
            cy0_reg <= CORDIC_W'(wcy_reg[lo_reg +: NORM_BITS]);
            yn5_reg <= yn4_reg;
            xn5_reg <= xn4_reg;
        end
    end

    // ---------------------------------------------------------------
    // CORDIC vectoring, one micro-rotation per stage.
    // ---------------------------------------------------------------
    logic signed [CORDIC_W-1:0] cx_reg [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] cy_reg [CORDIC_STEPS];
    logic signed [Z_W-1:0]      z_reg  [CORDIC_STEPS];
    logic                       yn_reg [CORDIC_STEPS];
    logic                       xn_reg [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        logic signed [CORDIC_W-1:0] cx_in;
        logic signed [CORDIC_W-1:0] cy_in;
        logic signed [Z_W-1:0]      z_in;
        logic                       yn_in;
        logic                       xn_in;

        if (i == 0) begin : g_first
            assign cx_in = cx0_reg;
            assign cy_in = cy0_reg;
            assign z_in  = '0;
            assign yn_in = yn5_reg;
            assign xn_in = xn5_reg;
        end else begin : g_next
            assign cx_in = cx_reg[i-1];
            assign cy_in = cy_reg[i-1];
            assign z_in  = z_reg[i-1];
            assign yn_in = yn_reg[i-1];
            assign xn_in = xn_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!cy_in[CORDIC_W-1])
                begin
                    cx_reg[i] <= cx_in + (cy_in >>> i);
                    cy_reg[i] <= cy_in - (cx_in >>> i);
                    z_reg[i]  <= z_in + atan_q24(i);
                end
                else
                begin
                    cx_reg[i] <= cx_in - (cy_in >>> i);
                    cy_reg[i] <= cy_in + (cx_in >>> i);
                    z_reg[i]  <= z_in - atan_q24(i);
                end
                yn_reg[i] <= yn_in;
                xn_reg[i] <= xn_in;
            end
        end
    end

    // ---------------------------------------------------------------
    // Final stage: quadrant fix-up, round half up to 2^-13, clamp.
    // ---------------------------------------------------------------
    logic signed [VW-1:0]      zq;
    logic signed [VW-1:0]      vq;
    logic signed [VW-1:0]      rq;
    logic signed [ANGLE_W-1:0] ang_reg;

    assign zq = xn_reg[CORDIC_STEPS-1] ? (VW'(PI_Q24) - VW'(z_reg[CORDIC_STEPS-1]))
                                       : VW'(z_reg[CORDIC_STEPS-1]);
    assign vq = yn_reg[CORDIC_STEPS-1] ? -zq : zq;
    assign rq = (vq + VW'(ROUND_BIAS)) >>> OUT_SHIFT;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (rq > VW'(ANGLE_MAX))
                ang_reg <= ANGLE_W'(ANGLE_MAX);
            else if (rq < -VW'(ANGLE_MAX))
                ang_reg <= ANGLE_W'(-ANGLE_MAX);
            else
                ang_reg <= ANGLE_W'(rq);
        end
    end

    // ---------------------------------------------------------------
    // Output register plus one skid entry; ready to the input side
    // comes from the skid flag alone.
    // ---------------------------------------------------------------
    assign incoming = en && vld_reg[TOT-1];
    assign take     = res.valid && res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= incoming;
        end
        else if (incoming)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
                out_ang_reg <= skid_ang_reg;
            else if (incoming)
                out_ang_reg <= ang_reg;
        end
        else if (incoming)
            skid_ang_reg <= ang_reg;
    end

    assign res.valid      = out_valid_reg;
    assign res.data.angle = out_ang_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a transaction while output register is empty");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_ang_reg <= ANGLE_W'(ANGLE_MAX)
                           && out_ang_reg >= -ANGLE_W'(ANGLE_MAX)))
        else $error("angle outside +/- pi");

endmodule
